>>> rtl/adc_reading_scaler_top_macros.svh
// Assertion macros for the ADC reading scaler RTL, used by its divider.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef ADC_READING_SCALER_TOP_MACROS_SVH
`define ADC_READING_SCALER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define ADC_RS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define ADC_RS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`else

`define ADC_RS_ASSERT(lbl, expr, msg)

`define ADC_RS_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/adc_rs_pkg.sv
// Package for the ADC reading scaler: widths, constants, channel kinds and
// the sideband struct that travels down the pipeline. No dependencies.
`default_nettype none

package adc_rs_pkg;

  localparam int unsigned ADC_BITS = 12;
  localparam int unsigned ADC_FULL = 1 << ADC_BITS;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RAW_W    = 2 * BYTE_W;
  localparam int unsigned RAWX_W   = 3 * BYTE_W;
  localparam int unsigned CLAMP_W  = ADC_BITS + 1;

  localparam int unsigned VREF_MV  = 2500;
  localparam int unsigned VREF_W   = 12;
  localparam int unsigned PROD_W   = CLAMP_W + VREF_W;

  localparam int unsigned DIV_W    = 16;
  localparam int unsigned SUM_W    = DIV_W + 1;
  localparam int unsigned OFFS_W   = 16;
  localparam int unsigned OUT_W    = 30;

  localparam int unsigned DIVIDEND_W = VREF_W + SUM_W;
  localparam int unsigned DIV_STAGES = DIVIDEND_W;
  localparam int unsigned QUOT_MAX   = VREF_MV * (2 ** DIV_W);

  localparam logic [RAW_W-1:0] TEMP_WRAP_LIMIT = 16'h8000;
  localparam logic [OUT_W-1:0] TEMP_WRAP_SUB   = 30'h0000_FFFF;

  typedef enum logic [1:0] {
    KIND_TEMP = 2'd0,
    KIND_VOLT = 2'd1,
    KIND_RAW  = 2'd2
  } kind_e;

  typedef struct packed {
    logic               is_raw;
    logic [OUT_W-1:0]   pass_val;
    logic [OFFS_W-1:0]  offset;
  } side_t;

endpackage

`default_nettype wire

>>> rtl/adc_rs_front.sv
// Front end of the ADC reading scaler: byte assembly, kind decode, clamp and
// reference scaling, then the divider-ratio multiply. Uses adc_rs_pkg.
`default_nettype none

module adc_rs_front
  import adc_rs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  vld_i,
  input  wire logic                  device_is_v3_i,
  input  wire logic [BYTE_W-1:0]     byte_low_i,
  input  wire logic [BYTE_W-1:0]     byte_mid_i,
  input  wire logic [BYTE_W-1:0]     byte_high_i,
  input  wire logic [1:0]            channel_kind_i,
  input  wire logic [DIV_W-1:0]      divider_top_i,
  input  wire logic [DIV_W-1:0]      divider_bottom_i,
  input  wire logic [OFFS_W-1:0]     voltage_offset_i,
  output logic                       vld_o,
  output logic [DIVIDEND_W-1:0]      dividend_o,
  output logic [DIV_W-1:0]           divisor_o,
  output side_t                      side_o
);

  logic [RAW_W-1:0]   raw16;
  logic [RAWX_W-1:0]  raw24;
  logic [CLAMP_W-1:0] clamped;
  logic [PROD_W-1:0]  prod;
  logic               div_en;
  side_t              side_d;

  logic [VREF_W-1:0]  volt_d, volt_q;
  logic [SUM_W-1:0]   sum_d, sum_q;
  logic [DIV_W-1:0]   bot_d, bot_q;
  side_t              side1_q;
  logic               vld1_q;

  logic [DIVIDEND_W-1:0] dividend_d, dividend_q;
  logic [DIV_W-1:0]      bot2_q;
  side_t                 side2_q;
  logic                  vld2_q;

  // Stage 1: assemble the reading and scale a raw voltage to millivolts.
  always_comb begin
    raw16   = {byte_mid_i, byte_low_i};
    raw24   = {byte_high_i, byte_mid_i, byte_low_i};
    clamped = ({1'b0, raw16} > 17'(ADC_FULL)) ? CLAMP_W'(ADC_FULL) : CLAMP_W'(raw16);
    prod    = PROD_W'(clamped) * PROD_W'(VREF_MV);
    volt_d  = VREF_W'(prod >> ADC_BITS);

    side_d.offset = voltage_offset_i;
    side_d.is_raw = (kind_e'(channel_kind_i) == KIND_RAW);
    case (kind_e'(channel_kind_i))
      KIND_TEMP: begin
        if (raw16 > TEMP_WRAP_LIMIT) begin
          side_d.pass_val = OUT_W'(raw16) - TEMP_WRAP_SUB;
        end else begin
          side_d.pass_val = OUT_W'(raw16);
        end
      end
      KIND_VOLT: begin
        side_d.pass_val = device_is_v3_i ? OUT_W'(raw16) : OUT_W'(raw24);
      end
      default: begin
        side_d.pass_val = OUT_W'(raw16);
      end
    endcase

    // An incomplete divider pair turns the ratio into 1/1.
    div_en = (divider_top_i != '0) && (divider_bottom_i != '0);
    sum_d  = div_en ? (SUM_W'(divider_top_i) + SUM_W'(divider_bottom_i)) : SUM_W'(1);
    bot_d  = div_en ? divider_bottom_i : DIV_W'(1);
  end

  // Stage 2: numerator of the divider ratio.
  always_comb begin
    dividend_d = DIVIDEND_W'(volt_q) * DIVIDEND_W'(sum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    volt_q     <= volt_d;
    sum_q      <= sum_d;
    bot_q      <= bot_d;
    side1_q    <= side_d;
    dividend_q <= dividend_d;
    bot2_q     <= bot_q;
    side2_q    <= side1_q;
  end

  assign vld_o      = vld2_q;
  assign dividend_o = dividend_q;
  assign divisor_o  = bot2_q;
  assign side_o     = side2_q;

endmodule

`default_nettype wire

>>> rtl/adc_rs_div.sv
// Pipelined restoring divider of the ADC reading scaler: one quotient bit per
// stage, sideband carried alongside. Uses adc_rs_pkg and the assertion macros.
`default_nettype none

`include "adc_reading_scaler_top_macros.svh"

module adc_rs_div
  import adc_rs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  vld_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0]      divisor_i,
  input  wire side_t                 side_i,
  output logic                       vld_o,
  output logic [DIVIDEND_W-1:0]      quot_o,
  output side_t                      side_o
);

  logic                  vld_q  [1:DIV_STAGES];
  logic [DIV_W-1:0]      rem_q  [1:DIV_STAGES];
  logic [DIVIDEND_W-1:0] dq_q   [1:DIV_STAGES];
  logic [DIV_W-1:0]      dvs_q  [1:DIV_STAGES];
  side_t                 side_q [1:DIV_STAGES];

  logic                  vld_in  [0:DIV_STAGES-1];
  logic [DIV_W-1:0]      rem_in  [0:DIV_STAGES-1];
  logic [DIVIDEND_W-1:0] dq_in   [0:DIV_STAGES-1];
  logic [DIV_W-1:0]      dvs_in  [0:DIV_STAGES-1];
  side_t                 side_in [0:DIV_STAGES-1];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [DIV_W:0]   trial;
    logic             ge;
    logic [DIV_W-1:0] rem_nx;

    if (i == 0) begin : g_first
      assign vld_in[i]  = vld_i;
      assign rem_in[i]  = '0;
      assign dq_in[i]   = dividend_i;
      assign dvs_in[i]  = divisor_i;
      assign side_in[i] = side_i;
    end else begin : g_next
      assign vld_in[i]  = vld_q[i];
      assign rem_in[i]  = rem_q[i];
      assign dq_in[i]   = dq_q[i];
      assign dvs_in[i]  = dvs_q[i];
      assign side_in[i] = side_q[i];
    end

    // The dividend register shifts its top bit into the partial remainder
    // and takes the new quotient bit in at the bottom.
    always_comb begin
      trial  = {rem_in[i], dq_in[i][DIVIDEND_W-1]};
      ge     = (trial >= {1'b0, dvs_in[i]});
      rem_nx = ge ? DIV_W'(trial - {1'b0, dvs_in[i]}) : DIV_W'(trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i+1]  <= rem_nx;
      dq_q[i+1]   <= {dq_in[i][DIVIDEND_W-2:0], ge};
      dvs_q[i+1]  <= dvs_in[i];
      side_q[i+1] <= side_in[i];
    end
  end

  assign vld_o  = vld_q[DIV_STAGES];
  assign quot_o = dq_q[DIV_STAGES];
  assign side_o = side_q[DIV_STAGES];

  `ADC_RS_ASSERT_IMP(a_div_latency, vld_i, ##DIV_STAGES vld_o, "divider lost an item")
  `ADC_RS_ASSERT_IMP(a_div_rem_bound, vld_o, (rem_q[DIV_STAGES] < dvs_q[DIV_STAGES]),
                     "final remainder not below divisor")
  `ADC_RS_ASSERT_IMP(a_div_quot_bound, vld_o && side_o.is_raw, (quot_o <= QUOT_MAX),
                     "scaled voltage exceeds its possible range")

endmodule

`default_nettype wire

>>> rtl/adc_reading_scaler_top.sv
// Top level of the ADC reading scaler: configuration register, front end,
// pipelined divider and offset stage. Uses adc_rs_pkg, adc_rs_front, adc_rs_div.
`default_nettype none

// Usage:
// Pulse start_i with the raw bytes, channel kind, divider pair and offset on
// the input ports; busy_o is always low, so an item is taken in every cycle
// that start_i is high. Exactly one result per item appears on
// converted_value_o for one cycle, marked by done_o, in the order the items
// were taken. Each item passes two front stages (assembly and reference
// scaling, then the ratio multiply), 29 divider stages that each resolve
// one quotient bit and one output stage that adds the offset or passes the
// value through; done_o rises when that output stage takes the result.
// Throughput is one item per cycle.
// The device_is_v3 register is written through cfg_valid_i with its value on
// device_is_v3_i; cfg_ready_o is always high. Write it only while no item
// is in flight. Reset clears the register to 0 and drops every item in the
// pipeline. The receiver must take each result in its strobe cycle.

module adc_reading_scaler_top
  import adc_rs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [BYTE_W-1:0] byte_low_i,
  input  wire logic [BYTE_W-1:0] byte_mid_i,
  input  wire logic [BYTE_W-1:0] byte_high_i,
  input  wire logic [1:0]        channel_kind_i,
  input  wire logic [DIV_W-1:0]  divider_top_i,
  input  wire logic [DIV_W-1:0]  divider_bottom_i,
  input  wire logic [OFFS_W-1:0] voltage_offset_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              device_is_v3_i,
  output logic                   done_o,
  output logic signed [OUT_W-1:0] converted_value_o
);

  logic dev_v3_d, dev_v3_q;

  logic                  fr_vld;
  logic [DIVIDEND_W-1:0] fr_dividend;
  logic [DIV_W-1:0]      fr_divisor;
  side_t                 fr_side;

  logic                  dv_vld;
  logic [DIVIDEND_W-1:0] dv_quot;
  side_t                 dv_side;

  logic [OUT_W-1:0] result_d, result_q;
  logic             done_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    dev_v3_d = dev_v3_q;
    if (cfg_valid_i && cfg_ready_o) begin
      dev_v3_d = device_is_v3_i;
    end
  end

  adc_rs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .vld_i            (start_i && !busy_o),
    .device_is_v3_i   (dev_v3_q),
    .byte_low_i       (byte_low_i),
    .byte_mid_i       (byte_mid_i),
    .byte_high_i      (byte_high_i),
    .channel_kind_i   (channel_kind_i),
    .divider_top_i    (divider_top_i),
    .divider_bottom_i (divider_bottom_i),
    .voltage_offset_i (voltage_offset_i),
    .vld_o            (fr_vld),
    .dividend_o       (fr_dividend),
    .divisor_o        (fr_divisor),
    .side_o           (fr_side)
  );

  adc_rs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (fr_vld),
    .dividend_i (fr_dividend),
    .divisor_i  (fr_divisor),
    .side_i     (fr_side),
    .vld_o      (dv_vld),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  always_comb begin
    if (dv_side.is_raw) begin
      result_d = OUT_W'(dv_quot) + OUT_W'(dv_side.offset);
    end else begin
      result_d = dv_side.pass_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_v3_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      dev_v3_q <= dev_v3_d;
      done_q   <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o            = done_q;
  assign converted_value_o = result_q;

endmodule

`default_nettype wire
